### rtl/pps_pkg.sv
package pps_pkg;

   localparam int CoordW  = 24;
   localparam int DiffW   = 25;
   localparam int CordicW = 58;
   localparam int AngleW  = 32;
   localparam int SinW    = 33;
   localparam int ProdW   = 50;
   localparam int TabLen  = 24;

   localparam logic [AngleW-1:0] HalfTurn = 32'h8000_0000;
   localparam logic signed [CordicW-1:0] SinSeed = 58'sd652032874;
   localparam logic signed [CordicW-1:0] UnitX   = 58'sh40_0000_0000;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [1:0] CSR_PATH_LENGTH  = 2'd0;
   localparam logic [1:0] CSR_SEARCH_START = 2'd1;
   localparam logic [1:0] CSR_STEER_GAIN   = 2'd2;

   localparam logic [15:0] GainReset = 16'd742;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_BEAR_GO,
      ST_BEAR_RUN,
      ST_SINE_GO,
      ST_SINE_RUN,
      ST_GAIN,
      ST_STEER_GO,
      ST_STEER_RUN
   } pps_state_type;

   typedef enum logic [1:0] {
      SR_IDLE,
      SR_SCAN,
      SR_FETCH,
      SR_DIFF
   } srch_state_type;

   typedef enum logic {
      CM_VECTOR,
      CM_ROTATE
   } cordic_mode_type;

   typedef struct packed {
      logic       done;
      logic       at_end;
      logic [5:0] target;
   } srch_rsp_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic [AngleW-1:0] atan_lut(input logic [4:0] i);
      logic [AngleW-1:0] v;
      case (i)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage

### rtl/pps_search.sv
module pps_search import pps_pkg::*; #(
   parameter int MAX_WAYPOINTS = 64,
   localparam int AW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1,
   localparam int LW = $clog2(MAX_WAYPOINTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  logic [5:0]               wr_slot,
   input  logic signed [CoordW-1:0] wr_x,
   input  logic signed [CoordW-1:0] wr_y,
   input  logic                     go,
   input  logic signed [CoordW-1:0] robot_x,
   input  logic signed [CoordW-1:0] robot_y,
   input  logic [LW-1:0]            len,
   input  logic [5:0]               first_idx,
   output srch_rsp_type             rsp,
   output logic signed [DiffW-1:0]  diff_x,
   output logic signed [DiffW-1:0]  diff_y
);

   logic signed [CoordW-1:0] mem_x [MAX_WAYPOINTS];
   logic signed [CoordW-1:0] mem_y [MAX_WAYPOINTS];

   srch_state_type state_ff, state_in;

   logic signed [CoordW-1:0] rd_x_ff, rd_y_ff, rx_ff, ry_ff;
   logic [AW-1:0] rd_addr, wr_addr, last, last_ff, first_ff, issue_ff;
   logic [AW-1:0] idx1_ff, idx2_ff, idx3_ff, target_ff;
   logic          wr_ok, issuing_ff, v1_ff, v2_ff, v3_ff, done_ff, past_end;
   logic [23:0]   ax_ff, ay_ff, ax_in, ay_in;
   logic [47:0]   sx_ff, sy_ff;
   logic [48:0]   best_ff, dist_sum;
   logic signed [DiffW-1:0] ex, ey, dx_ff, dy_ff;

   assign wr_ok    = 32'(wr_slot) < MAX_WAYPOINTS;
   assign wr_addr  = AW'(wr_slot);
   assign last     = AW'(len - LW'(1));
   assign past_end = 32'(first_idx) >= 32'(len);
   assign rd_addr  = (state_ff == SR_FETCH) ? target_ff : issue_ff;

   always_ff @(posedge clock) begin
      if (wr_en && wr_ok) begin
         mem_x[wr_addr] <= wr_x;
         mem_y[wr_addr] <= wr_y;
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   // distance pipe: read, abs diff, square, sum and compare
   assign ex       = DiffW'(rx_ff) - DiffW'(rd_x_ff);
   assign ey       = DiffW'(ry_ff) - DiffW'(rd_y_ff);
   assign ax_in    = ex[DiffW-1] ? 24'(-ex) : 24'(ex);
   assign ay_in    = ey[DiffW-1] ? 24'(-ey) : 24'(ey);
   assign dist_sum = {1'b0, sx_ff} + {1'b0, sy_ff};

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SR_IDLE:  if (go) state_in = past_end ? SR_FETCH : SR_SCAN;
         SR_SCAN:  if (!issuing_ff && !v1_ff && !v2_ff && !v3_ff) state_in = SR_FETCH;
         SR_FETCH: state_in = SR_DIFF;
         SR_DIFF:  state_in = SR_IDLE;
         default:  state_in = SR_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SR_IDLE;
         issuing_ff <= 1'b0;
         v1_ff      <= 1'b0;
         v2_ff      <= 1'b0;
         v3_ff      <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         v1_ff    <= (state_ff == SR_SCAN) && issuing_ff;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         done_ff  <= (state_ff == SR_DIFF);
         if (state_ff == SR_IDLE && go) begin
            issuing_ff <= !past_end;
         end else if (state_ff == SR_SCAN && issuing_ff && issue_ff == last_ff) begin
            issuing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == SR_IDLE && go) begin
         rx_ff     <= robot_x;
         ry_ff     <= robot_y;
         last_ff   <= last;
         first_ff  <= AW'(first_idx);
         issue_ff  <= AW'(first_idx);
         target_ff <= last;
      end
      if (state_ff == SR_SCAN && issuing_ff && issue_ff != last_ff) begin
         issue_ff <= issue_ff + AW'(1);
      end
      idx1_ff <= issue_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      ax_ff   <= ax_in;
      ay_ff   <= ay_in;
      sx_ff   <= ax_ff * ax_ff;
      sy_ff   <= ay_ff * ay_ff;
      // first entry always taken, later ones only if strictly nearer
      if (v3_ff && (idx3_ff == first_ff || dist_sum < best_ff)) begin
         best_ff   <= dist_sum;
         target_ff <= idx3_ff;
      end
      if (state_ff == SR_DIFF) begin
         dx_ff <= DiffW'(rd_x_ff) - DiffW'(rx_ff);
         dy_ff <= DiffW'(rd_y_ff) - DiffW'(ry_ff);
      end
   end

   assign rsp.done   = done_ff;
   assign rsp.at_end = (target_ff == last_ff);
   assign rsp.target = 6'(target_ff);
   assign diff_x     = dx_ff;
   assign diff_y     = dy_ff;

endmodule

### rtl/pps_cordic.sv
module pps_cordic import pps_pkg::*; #(
   parameter int ITERATIONS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      go,
   input  cordic_mode_type           mode,
   input  logic signed [CordicW-1:0] x0,
   input  logic signed [CordicW-1:0] y0,
   input  logic [AngleW-1:0]         z0,
   output logic                      done,
   output logic signed [CordicW-1:0] y_out,
   output logic [AngleW-1:0]         z_out
);

   localparam int Steps = (ITERATIONS > TabLen) ? TabLen : ITERATIONS;
   localparam logic [4:0] LastStep = 5'(Steps - 1);

   logic signed [CordicW-1:0] x_ff, y_ff, xs, ys;
   logic [AngleW-1:0] z_ff, ang;
   cordic_mode_type   mode_ff;
   logic [4:0]        step_ff;
   logic              run_ff, done_ff, turn_pos;

   assign xs  = x_ff >>> step_ff;
   assign ys  = y_ff >>> step_ff;
   assign ang = atan_lut(step_ff);
   // positive rotation: vectoring with y below zero, rotating with z at or above zero
   assign turn_pos = (mode_ff == CM_VECTOR) ? y_ff[CordicW-1] : !z_ff[AngleW-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= 5'd0;
      end else begin
         done_ff <= run_ff && (step_ff == LastStep);
         if (go) begin
            run_ff  <= 1'b1;
            step_ff <= 5'd0;
         end else if (run_ff) begin
            if (step_ff == LastStep) run_ff <= 1'b0;
            step_ff <= step_ff + 5'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         x_ff    <= x0;
         y_ff    <= y0;
         z_ff    <= z0;
         mode_ff <= mode;
      end else if (run_ff) begin
         if (turn_pos) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - ang;
         end else begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + ang;
         end
      end
   end

   assign done  = done_ff;
   assign y_out = y_ff;
   assign z_out = z_ff;

endmodule

### rtl/pure_pursuit_steering.sv
// Pure pursuit steering with an on-chip waypoint table.
// Input items: start is sampled with busy low. req_command selects a waypoint
//   load (slot, x, y written into the table, done in the accept cycle, no
//   result) or a steering query (robot x, y and heading).
// Results: one per query, shown for one cycle with rsp_valid high. The
//   receiver cannot stall; it must take the item in that cycle.
// Config: csr_write with csr_index/csr_data, written by the user while the
//   block is idle; the block itself does not enforce it.
// Query: the nearest search reads one waypoint per cycle from the table's
//   single read port, then one shared CORDIC unit runs bearing, sine and
//   arctangent, one iteration a cycle.
//   An empty path answers in the cycle right after accept (no_path set).
// Busy stays high while a non-empty query runs; a load never raises busy.
// Reset: registers return to path_length 0, search_start 0, gain 742 and the
//   FSMs idle. The table is not cleared; entries are undefined until loaded.
module pure_pursuit_steering import pps_pkg::*; #(
   parameter int MAX_WAYPOINTS     = 64,
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_command,
   input  logic [5:0]               req_waypoint_slot,
   input  logic signed [CoordW-1:0] req_point_x,
   input  logic signed [CoordW-1:0] req_point_y,
   input  logic [15:0]              req_heading,
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_steer_angle,
   output logic [5:0]               rsp_target_index,
   output logic                     rsp_at_end,
   output logic                     rsp_no_path,
   input  logic                     csr_write,
   input  logic [1:0]               csr_index,
   input  logic [15:0]              csr_data
);

   localparam int LW = $clog2(MAX_WAYPOINTS + 1);

   pps_state_type state_ff, state_in;

   // config registers
   logic [6:0]  csr_path_length_ff;
   logic [5:0]  csr_search_start_ff;
   logic [15:0] csr_steer_gain_ff;

   logic [LW-1:0] len_eff;
   logic          accept, take_load, take_query, empty_path, robot_on_target;

   srch_rsp_type            srch_rsp;
   logic signed [DiffW-1:0] diff_x, diff_y;

   logic                      cdc_go, cdc_done;
   cordic_mode_type           cdc_mode;
   logic signed [CordicW-1:0] cdc_x0, cdc_y0, cdc_y, bx, by;
   logic [AngleW-1:0]         cdc_z0, cdc_z, alpha;

   logic [15:0]            heading_ff;
   logic [AngleW-1:0]      bearing_ff;
   logic signed [SinW-1:0] sin_ff;
   logic signed [ProdW-1:0] t_ff;
   logic signed [32:0]     steer_round;

   logic              rsp_valid_ff, rsp_at_end_ff, rsp_no_path_ff;
   logic signed [15:0] rsp_steer_angle_ff;
   logic [5:0]        rsp_target_index_ff;

   // long paths saturate to the table depth
   always_comb begin
      if (32'(csr_path_length_ff) > 32'(MAX_WAYPOINTS)) begin
         len_eff = LW'(MAX_WAYPOINTS);
      end else begin
         len_eff = LW'(csr_path_length_ff);
      end
   end

   assign accept          = start && !busy;
   assign take_load       = accept && (req_command == CMD_LOAD);
   assign take_query      = accept && (req_command == CMD_QUERY);
   assign empty_path      = (len_eff == LW'(0));
   assign robot_on_target = (diff_x == '0) && (diff_y == '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_path_length_ff  <= 7'd0;
         csr_search_start_ff <= 6'd0;
         csr_steer_gain_ff   <= GainReset;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_PATH_LENGTH:  csr_path_length_ff  <= csr_data[6:0];
            CSR_SEARCH_START: csr_search_start_ff <= csr_data[5:0];
            CSR_STEER_GAIN:   csr_steer_gain_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   pps_search #(
      .MAX_WAYPOINTS(MAX_WAYPOINTS)
   ) u_search (
      .clock     (clock),
      .reset     (reset),
      .wr_en     (take_load),
      .wr_slot   (req_waypoint_slot),
      .wr_x      (req_point_x),
      .wr_y      (req_point_y),
      .go        (take_query && !empty_path),
      .robot_x   (req_point_x),
      .robot_y   (req_point_y),
      .len       (len_eff),
      .first_idx (csr_search_start_ff),
      .rsp       (srch_rsp),
      .diff_x    (diff_x),
      .diff_y    (diff_y)
   );

   pps_cordic #(
      .ITERATIONS(CORDIC_ITERATIONS)
   ) u_cordic (
      .clock (clock),
      .reset (reset),
      .go    (cdc_go),
      .mode  (cdc_mode),
      .x0    (cdc_x0),
      .y0    (cdc_y0),
      .z0    (cdc_z0),
      .done  (cdc_done),
      .y_out (cdc_y),
      .z_out (cdc_z)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (take_query && !empty_path) state_in = ST_SEARCH;
         ST_SEARCH:    if (srch_rsp.done) state_in = ST_BEAR_GO;
         ST_BEAR_GO:   state_in = robot_on_target ? ST_SINE_GO : ST_BEAR_RUN;
         ST_BEAR_RUN:  if (cdc_done) state_in = ST_SINE_GO;
         ST_SINE_GO:   state_in = ST_SINE_RUN;
         ST_SINE_RUN:  if (cdc_done) state_in = ST_GAIN;
         ST_GAIN:      state_in = ST_STEER_GO;
         ST_STEER_GO:  state_in = ST_STEER_RUN;
         ST_STEER_RUN: if (cdc_done) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // bearing input: scale by 2^30, turn left half plane by half a turn
   assign bx    = CordicW'(diff_x) <<< 30;
   assign by    = CordicW'(diff_y) <<< 30;
   assign alpha = bearing_ff - {heading_ff, 16'h0000};

   // outputs of the sequencer
   always_comb begin
      busy     = (state_ff != ST_IDLE);
      cdc_go   = 1'b0;
      cdc_mode = CM_VECTOR;
      cdc_x0   = UnitX;
      cdc_y0   = CordicW'(t_ff);
      cdc_z0   = '0;
      unique case (state_ff)
         ST_BEAR_GO: begin
            cdc_go = !robot_on_target;
            if (diff_x[DiffW-1]) begin
               cdc_x0 = -bx;
               cdc_y0 = -by;
               cdc_z0 = HalfTurn;
            end else begin
               cdc_x0 = bx;
               cdc_y0 = by;
            end
         end
         ST_SINE_GO: begin
            cdc_go   = 1'b1;
            cdc_mode = CM_ROTATE;
            cdc_x0   = SinSeed;
            cdc_y0   = '0;
            // fold into the right half plane: a quarter to three quarters turn
            cdc_z0   = (alpha[31] ^ alpha[30]) ? (HalfTurn - alpha) : alpha;
         end
         ST_STEER_GO: begin
            cdc_go = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (take_query && empty_path) ||
                         (state_ff == ST_STEER_RUN && cdc_done);
      end
   end

   // arctangent result rounded to 16 bits
   assign steer_round = 33'(signed'(cdc_z)) + 33'sd32768;

   always_ff @(posedge clock) begin
      if (take_query) heading_ff <= req_heading;
      if (state_ff == ST_BEAR_GO) bearing_ff <= '0;
      if (state_ff == ST_BEAR_RUN && cdc_done) bearing_ff <= cdc_z;
      if (state_ff == ST_SINE_RUN && cdc_done) sin_ff <= SinW'(cdc_y);
      if (state_ff == ST_GAIN) t_ff <= signed'({1'b0, csr_steer_gain_ff}) * sin_ff;
      if (take_query && empty_path) begin
         rsp_steer_angle_ff  <= '0;
         rsp_target_index_ff <= '0;
         rsp_at_end_ff       <= 1'b0;
         rsp_no_path_ff      <= 1'b1;
      end else if (state_ff == ST_STEER_RUN && cdc_done) begin
         rsp_steer_angle_ff  <= 16'(steer_round >>> 16);
         rsp_target_index_ff <= srch_rsp.target;
         rsp_at_end_ff       <= srch_rsp.at_end;
         rsp_no_path_ff      <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_steer_angle  = rsp_steer_angle_ff;
   assign rsp_target_index = rsp_target_index_ff;
   assign rsp_at_end       = rsp_at_end_ff;
   assign rsp_no_path      = rsp_no_path_ff;

endmodule

### rtl/pps_check.sv
module pps_check (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              req_command,
   input logic              rsp_valid,
   input logic signed [15:0] rsp_steer_angle,
   input logic [5:0]        rsp_target_index,
   input logic              rsp_at_end,
   input logic              rsp_no_path
);

   // empty path result carries only the flag
   a_no_path_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_path |->
         rsp_steer_angle == 16'sd0 && rsp_target_index == 6'd0 && !rsp_at_end)
      else $error("no_path item with nonzero fields");

   // a load never produces an item
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_command |=> !rsp_valid)
      else $error("item after load");

   // a query either starts work or answers at once
   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command |=> busy || rsp_valid)
      else $error("query dropped");

   // items only appear once the block is back to idle
   a_valid_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("item while busy");

   // steering stays within a quarter turn
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_no_path |->
         rsp_steer_angle >= -16'sd16384 && rsp_steer_angle <= 16'sd16384)
      else $error("steer angle out of range");

endmodule

bind pure_pursuit_steering pps_check u_pps_check (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_command      (req_command),
   .rsp_valid        (rsp_valid),
   .rsp_steer_angle  (rsp_steer_angle),
   .rsp_target_index (rsp_target_index),
   .rsp_at_end       (rsp_at_end),
   .rsp_no_path      (rsp_no_path)
);
